[hdl/spectrum_bar_graph_macros.svh]
// Assertion macros shared by the spectrum bar graph RTL.
`ifndef SPECTRUM_BAR_GRAPH_MACROS_SVH
`define SPECTRUM_BAR_GRAPH_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SBG_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SBG_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/sbg_pkg.sv]
// Shared types and constants of the spectrum bar graph.
package sbg_pkg;

    localparam int SQ_IN_W   = 32;
    localparam int SQ_ROOT_W = 16;
    localparam int SQ_CNT_W  = $clog2(SQ_ROOT_W);

    localparam int DIV_W     = 16;
    localparam int DIVR_W    = 8;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam int SUM_W     = 14;
    localparam int SUM_LIMIT = 16383;
    localparam int CFG_W     = 8;

    localparam int AVG_SHIFT = 17;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_RE,
        ST_SQ_IM,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_AVG,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        CFG_DIVISOR   = 2'd0,
        CFG_FIRST_BIN = 2'd1,
        CFG_YELLOW    = 2'd2,
        CFG_RED       = 2'd3
    } cfg_index_t;

endpackage

[hdl/sbg_isqrt.sv]
// Bit-serial integer square root, one root bit per cycle.
module sbg_isqrt (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [sbg_pkg::SQ_IN_W-1:0]    radicand,
    output logic [sbg_pkg::SQ_ROOT_W-1:0]  root,
    output sbg_pkg::unit_stat_t            stat
);

    localparam int RW = sbg_pkg::SQ_ROOT_W;

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [sbg_pkg::SQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic [sbg_pkg::SQ_IN_W-1:0]  x_reg, x_next;
    logic [RW+1:0]                rem_reg, rem_next;
    logic [RW-1:0]                root_reg, root_next;
    logic [RW+3:0]                rem_sh;
    logic [RW+3:0]                trial;
    logic                         fits;

    assign rem_sh = {rem_reg, x_reg[sbg_pkg::SQ_IN_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign fits   = rem_sh >= trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = busy_reg && (cnt_reg == '0);
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = sbg_pkg::SQ_CNT_W'(RW - 1);
            x_next    = radicand;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            x_next = {x_reg[sbg_pkg::SQ_IN_W-3:0], 2'b00};
            if (fits) begin
                rem_next  = (RW + 2)'(rem_sh - trial);
                root_next = {root_reg[RW-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh[RW+1:0];
                root_next = {root_reg[RW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root      = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[hdl/sbg_divider.sv]
// Restoring divider, one quotient bit per cycle.
module sbg_divider (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [sbg_pkg::DIV_W-1:0]   dividend,
    input  logic [sbg_pkg::DIVR_W-1:0]  divisor,
    output logic [sbg_pkg::DIV_W-1:0]   quotient,
    output sbg_pkg::unit_stat_t         stat
);

    localparam int QW = sbg_pkg::DIV_W;
    localparam int VW = sbg_pkg::DIVR_W;

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [sbg_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [QW-1:0]                 q_reg, q_next;
    logic [VW-1:0]                 rem_reg, rem_next;
    logic [VW-1:0]                 dvs_reg, dvs_next;
    logic [VW:0]                   rem_sh;
    logic                          fits;

    assign rem_sh = {rem_reg, q_reg[QW-1]};
    assign fits   = rem_sh >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = busy_reg && (cnt_reg == '0);
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = sbg_pkg::DIV_CNT_W'(QW - 1);
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = VW'(rem_sh - {1'b0, dvs_reg});
            end else begin
                rem_next = rem_sh[VW-1:0];
            end
            q_next   = {q_reg[QW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[hdl/spectrum_bar_graph.sv]
// Spectrum bar graph: turns FFT bins into bar heights and color band pixel counts.
// A bin that feeds a bar is worked after its acceptance on one shared 16x16 multiplier that
// squares the real and imaginary parts, then on the bit-serial square root, and then on the
// restoring divider, which divides by the configured divisor. A bin that closes a bar then
// takes the group average by a reciprocal multiply and loads the result register; that
// load waits while the previous bar is still pending. Bins outside any bar are taken while
// s_ready stays high. s_ready is low while a bin is being worked; a finished bar waits in
// the output register so the next bin can be taken while the result is still pending.
`include "spectrum_bar_graph_macros.svh"

module spectrum_bar_graph #(
    parameter int FFT_POINTS   = 1024,
    parameter int BAR_COUNT    = 160,
    parameter int BINS_PER_BAR = 3,
    parameter int MAX_HEIGHT   = 128
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [1:0]                 cfg_index,
    input  logic [sbg_pkg::CFG_W-1:0]  cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [15:0]         s_bin_real,
    input  logic signed [15:0]         s_bin_imag,
    input  logic                       s_frame_start,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [8:0]                 m_column,
    output logic [7:0]                 m_height,
    output logic [6:0]                 m_lime_count,
    output logic [7:0]                 m_yellow_count,
    output logic [7:0]                 m_red_count,
    output logic [7:0]                 m_black_count,
    output logic                       m_last_bar
);

    localparam int HALF_BINS = FFT_POINTS / 2;
    localparam int BIN_W     = $clog2(HALF_BINS) + 1;
    localparam int BAR_W     = $clog2(BAR_COUNT + 1);
    localparam int GP_W      = (BINS_PER_BAR > 1) ? $clog2(BINS_PER_BAR) : 1;
    localparam int SW        = sbg_pkg::SUM_W;
    localparam int AW        = sbg_pkg::AVG_SHIFT;
    localparam int PW        = SW + AW + 1;
    localparam logic [AW:0] AVG_RECIP = (AW + 1)'((2 ** AW + BINS_PER_BAR - 1) / BINS_PER_BAR);

    sbg_pkg::state_t              state_reg, state_next;
    logic [7:0]                   divisor_reg, divisor_next;
    logic [5:0]                   first_bin_reg, first_bin_next;
    logic [7:0]                   yellow_reg, yellow_next;
    logic [7:0]                   red_reg, red_next;
    logic [BIN_W-1:0]             bin_index_reg, bin_index_next;
    logic [SW-1:0]                group_sum_reg, group_sum_next;
    logic [GP_W-1:0]              group_pos_reg, group_pos_next;
    logic [BAR_W-1:0]             bar_index_reg, bar_index_next;
    logic                         m_valid_reg, m_valid_next;

    logic [15:0]                  ur_reg, ur_next;
    logic [15:0]                  ui_reg, ui_next;
    logic                         last_pend_reg, last_pend_next;
    logic [31:0]                  prod_reg, prod_next;
    logic [31:0]                  sumsq_reg, sumsq_next;
    logic [7:0]                   height_reg, height_next;
    logic [8:0]                   col_reg, col_next;
    logic [7:0]                   ht_out_reg, ht_out_next;
    logic [6:0]                   lime_reg, lime_next;
    logic [7:0]                   yel_out_reg, yel_out_next;
    logic [7:0]                   red_out_reg, red_out_next;
    logic [7:0]                   black_reg, black_next;
    logic                         last_reg, last_next;

    logic [BIN_W-1:0]             idx_cur;
    logic [BAR_W-1:0]             bar_cur;
    logic                         bin_active;
    logic                         s_fire;
    logic [15:0]                  mul_op;
    logic [31:0]                  mul_prod;
    logic [7:0]                   div_eff;
    logic [sbg_pkg::DIV_W:0]      sum_wide;
    logic [SW-1:0]                sum_sat;
    logic [PW-1:0]                avg_prod;
    logic [SW-1:0]                avg_quot;

    logic                         sqrt_start;
    logic [sbg_pkg::SQ_ROOT_W-1:0] sqrt_root;
    sbg_pkg::unit_stat_t          sqrt_stat;
    logic                         div_start;
    logic [sbg_pkg::DIV_W-1:0]    div_dividend;
    logic [sbg_pkg::DIVR_W-1:0]   div_divisor;
    logic [sbg_pkg::DIV_W-1:0]    div_quot;
    sbg_pkg::unit_stat_t          div_stat;

    logic [8:0]                   ys9, rs9, hp1, lime_hi;
    logic [8:0]                   lime9, yel9, red9;
    logic [8:0]                   count_total;

    function automatic logic [8:0] span(input logic [8:0] lo, input logic [8:0] excl);
        span = (excl > lo) ? excl - lo : 9'd0;
    endfunction

    function automatic logic [8:0] min9(input logic [8:0] a, input logic [8:0] b);
        min9 = (a < b) ? a : b;
    endfunction

    function automatic logic [8:0] max1(input logic [8:0] a);
        max1 = (a == 9'd0) ? 9'd1 : a;
    endfunction

    sbg_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sumsq_reg),
        .root     (sqrt_root),
        .stat     (sqrt_stat)
    );

    sbg_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    assign s_ready = (state_reg == sbg_pkg::ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    assign idx_cur    = s_frame_start ? '0 : bin_index_reg;
    assign bar_cur    = s_frame_start ? '0 : bar_index_reg;
    assign bin_active = (idx_cur < BIN_W'(HALF_BINS)) && (idx_cur >= BIN_W'(first_bin_reg))
                        && (bar_cur < BAR_W'(BAR_COUNT));

    assign mul_op   = (state_reg == sbg_pkg::ST_SQ_RE) ? ur_reg : ui_reg;
    assign mul_prod = mul_op * mul_op;

    assign div_eff      = (divisor_reg == 8'd0) ? 8'd1 : divisor_reg;
    assign sqrt_start   = (state_reg == sbg_pkg::ST_ROOT_GO);
    assign div_start    = (state_reg == sbg_pkg::ST_DIV_GO);
    assign div_dividend = sqrt_root;
    assign div_divisor  = div_eff;

    assign sum_wide = (sbg_pkg::DIV_W + 1)'(group_sum_reg) + (sbg_pkg::DIV_W + 1)'(div_quot);
    assign sum_sat  = (sum_wide > (sbg_pkg::DIV_W + 1)'(sbg_pkg::SUM_LIMIT))
                      ? SW'(sbg_pkg::SUM_LIMIT) : sum_wide[SW-1:0];

    assign avg_prod = PW'(group_sum_reg) * PW'(AVG_RECIP);
    assign avg_quot = avg_prod[AW +: SW];

    assign ys9     = (yellow_reg > 8'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : {1'b0, yellow_reg};
    assign rs9     = (red_reg > 8'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : {1'b0, red_reg};
    assign hp1     = {1'b0, height_reg} + 9'd1;
    assign lime_hi = min9(ys9, rs9);
    assign lime9   = span(9'd1, min9(lime_hi, hp1));
    assign yel9    = span(max1(ys9), min9(rs9, hp1));
    assign red9    = span(max1(rs9), hp1);

    always_comb begin
        state_next     = state_reg;
        divisor_next   = divisor_reg;
        first_bin_next = first_bin_reg;
        yellow_next    = yellow_reg;
        red_next       = red_reg;
        bin_index_next = bin_index_reg;
        group_sum_next = group_sum_reg;
        group_pos_next = group_pos_reg;
        bar_index_next = bar_index_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        ur_next        = ur_reg;
        ui_next        = ui_reg;
        last_pend_next = last_pend_reg;
        prod_next      = prod_reg;
        sumsq_next     = sumsq_reg;
        height_next    = height_reg;
        col_next       = col_reg;
        ht_out_next    = ht_out_reg;
        lime_next      = lime_reg;
        yel_out_next   = yel_out_reg;
        red_out_next   = red_out_reg;
        black_next     = black_reg;
        last_next      = last_reg;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                sbg_pkg::CFG_DIVISOR:   divisor_next   = cfg_wr_data;
                sbg_pkg::CFG_FIRST_BIN: first_bin_next = cfg_wr_data[5:0];
                sbg_pkg::CFG_YELLOW:    yellow_next    = cfg_wr_data;
                sbg_pkg::CFG_RED:       red_next       = cfg_wr_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            sbg_pkg::ST_IDLE: begin
                if (s_fire) begin
                    bin_index_next = (idx_cur < BIN_W'(HALF_BINS)) ? idx_cur + 1'b1 : idx_cur;
                    bar_index_next = bar_cur;
                    if (s_frame_start) begin
                        group_sum_next = '0;
                        group_pos_next = '0;
                    end
                    if (bin_active) begin
                        ur_next        = s_bin_real[15] ? 16'(~s_bin_real + 16'sd1)
                                                        : 16'(s_bin_real);
                        ui_next        = s_bin_imag[15] ? 16'(~s_bin_imag + 16'sd1)
                                                        : 16'(s_bin_imag);
                        last_pend_next = (bar_cur == BAR_W'(BAR_COUNT - 1))
                                         || (idx_cur == BIN_W'(HALF_BINS - 1));
                        state_next     = sbg_pkg::ST_SQ_RE;
                    end
                end
            end
            sbg_pkg::ST_SQ_RE: begin
                prod_next  = mul_prod;
                state_next = sbg_pkg::ST_SQ_IM;
            end
            sbg_pkg::ST_SQ_IM: begin
                sumsq_next = prod_reg + mul_prod;
                state_next = sbg_pkg::ST_ROOT_GO;
            end
            sbg_pkg::ST_ROOT_GO: begin
                state_next = sbg_pkg::ST_ROOT_WAIT;
            end
            sbg_pkg::ST_ROOT_WAIT: begin
                if (sqrt_stat.done) begin
                    state_next = sbg_pkg::ST_DIV_GO;
                end
            end
            sbg_pkg::ST_DIV_GO: begin
                state_next = sbg_pkg::ST_DIV_WAIT;
            end
            sbg_pkg::ST_DIV_WAIT: begin
                if (div_stat.done) begin
                    group_sum_next = sum_sat;
                    if (group_pos_reg == GP_W'(BINS_PER_BAR - 1)) begin
                        state_next = sbg_pkg::ST_AVG;
                    end else begin
                        group_pos_next = group_pos_reg + 1'b1;
                        state_next     = sbg_pkg::ST_IDLE;
                    end
                end
            end
            sbg_pkg::ST_AVG: begin
                height_next = (avg_quot > SW'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT) : avg_quot[7:0];
                state_next  = sbg_pkg::ST_EMIT;
            end
            sbg_pkg::ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    col_next       = 9'(bar_index_reg) << 1;
                    ht_out_next    = height_reg;
                    lime_next      = lime9[6:0];
                    yel_out_next   = yel9[7:0];
                    red_out_next   = red9[7:0];
                    black_next     = 8'(MAX_HEIGHT) - height_reg;
                    last_next      = last_pend_reg;
                    group_sum_next = '0;
                    group_pos_next = '0;
                    bar_index_next = bar_index_reg + 1'b1;
                    state_next     = sbg_pkg::ST_IDLE;
                end
            end
            default: state_next = sbg_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sbg_pkg::ST_IDLE;
            divisor_reg   <= 8'd14;
            first_bin_reg <= 6'd16;
            yellow_reg    <= 8'd32;
            red_reg       <= 8'd64;
            bin_index_reg <= '0;
            group_sum_reg <= '0;
            group_pos_reg <= '0;
            bar_index_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            divisor_reg   <= divisor_next;
            first_bin_reg <= first_bin_next;
            yellow_reg    <= yellow_next;
            red_reg       <= red_next;
            bin_index_reg <= bin_index_next;
            group_sum_reg <= group_sum_next;
            group_pos_reg <= group_pos_next;
            bar_index_reg <= bar_index_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ur_reg        <= ur_next;
        ui_reg        <= ui_next;
        last_pend_reg <= last_pend_next;
        prod_reg      <= prod_next;
        sumsq_reg     <= sumsq_next;
        height_reg    <= height_next;
        col_reg       <= col_next;
        ht_out_reg    <= ht_out_next;
        lime_reg      <= lime_next;
        yel_out_reg   <= yel_out_next;
        red_out_reg   <= red_out_next;
        black_reg     <= black_next;
        last_reg      <= last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_column       = col_reg;
    assign m_height       = ht_out_reg;
    assign m_lime_count   = lime_reg;
    assign m_yellow_count = yel_out_reg;
    assign m_red_count    = red_out_reg;
    assign m_black_count  = black_reg;
    assign m_last_bar     = last_reg;

    assign count_total = {2'b00, m_lime_count} + {1'b0, m_yellow_count}
                         + {1'b0, m_red_count} + {1'b0, m_black_count};

    `SBG_ASSERT_NXT(a_busy_after_bin, aclk, aresetn, s_fire && bin_active, !s_ready,
                    "bin in a bar did not start work")
    `SBG_ASSERT_IMP(a_units_idle, aclk, aresetn, state_reg == sbg_pkg::ST_IDLE,
                    !sqrt_stat.busy && !div_stat.busy, "arithmetic unit busy while idle")
    `SBG_ASSERT_IMP(a_height_range, aclk, aresetn, m_valid, m_height <= 8'(MAX_HEIGHT),
                    "bar height above limit")
    `SBG_ASSERT_IMP(a_band_total, aclk, aresetn, m_valid && (MAX_HEIGHT <= 128),
                    count_total == 9'(MAX_HEIGHT), "band counts do not cover the column")

endmodule
